@@ hw/rtl/frba_pkg.sv @@
// Shared definitions for the frame ring buffer allocator.
// Holds the action and status codes and the default sizing constants.
// No dependencies.
`timescale 1ns / 1ps

package frba_pkg;

  localparam int BUF_BYTES_DEF = 256;
  localparam int NUM_SLOTS_DEF = 8;

  typedef enum logic [1:0] {
    ACT_REQUEST = 2'd0,
    ACT_MARK    = 2'd1,
    ACT_PEEK    = 2'd2,
    ACT_RELEASE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_SLOT   = 2'd1,
    ST_NO_SPACE  = 2'd2,
    ST_NOT_READY = 2'd3
  } status_t;

endpackage

@@ hw/rtl/frba_start_mem.sv @@
// Start offset store for the descriptor slots, one write port and one
// registered read port with write-through. Uses frba_pkg for defaults.
`timescale 1ns / 1ps

module frba_start_mem #(
  parameter int DEPTH = frba_pkg::NUM_SLOTS_DEF,
  parameter int WIDTH = $clog2(frba_pkg::BUF_BYTES_DEF + 1),
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // A write to the address being read is passed through to the registered read data, so the read returns the new value.
  always_ff @(posedge clk) begin
    if (we && (waddr == raddr)) begin
      rdata <= wdata;
    end else begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ hw/rtl/frame_ring_buffer_allocator.sv @@
// Frame ring buffer allocator: descriptor ring and space manager for a byte buffer.
// Depends on frba_pkg and frba_start_mem.
`timescale 1ns / 1ps

// The block hands out space in a byte buffer of BUF_BYTES bytes, one frame
// per descriptor slot, with NUM_SLOTS slots used as a ring. Each input
// transfer carries an action: request space for a frame of alloc_size bytes,
// mark target_slot finished, peek at the oldest finished frame, or release it.
// Every input transfer produces exactly one output transfer carrying status,
// slot_out and offset_out.
// Both channels use valid and ready. An accepted item is decided in the cycle
// of its transfer and its result appears in the output register on the next
// cycle. One item can be taken every cycle while the receiver takes each result.
// That rate is set by the single update of the descriptor state per cycle:
// all actions touch only directly indexed registers.
// The start offset of the oldest slot is held in a register; the start of the
// slot after it is prefetched from the start store each cycle, so a release
// can move on to the next frame without a second read in the same cycle.
// When the receiver stalls the result stays in the output register and
// in_ready drops, so no further input is taken until the result is taken.
// Synchronous reset clears all slot marks, the write offset and both ring
// indexes, and empties the output register. Start offsets are not cleared;
// they are only read for slots marked valid.

module frame_ring_buffer_allocator #(
  parameter int BUF_BYTES = frba_pkg::BUF_BYTES_DEF,
  parameter int NUM_SLOTS = frba_pkg::NUM_SLOTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic [8:0] alloc_size,
  input  logic [2:0] target_slot,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] status,
  output logic [2:0] slot_out,
  output logic [7:0] offset_out
);

  // Offsets must be able to hold BUF_BYTES itself (a zero-size frame at the end).
  localparam int OW = $clog2(BUF_BYTES + 1);
  localparam int IW = $clog2(NUM_SLOTS);
  localparam int SW = ((OW > 9) ? OW : 9) + 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(NUM_SLOTS - 1);

  // Descriptor state.
  logic [NUM_SLOTS-1:0] slot_valid;
  logic [NUM_SLOTS-1:0] slot_done;
  logic [OW-1:0]        write_offset;
  logic [IW-1:0]        alloc_index;
  logic [IW-1:0]        oldest_index;
  logic [OW-1:0]        oldest_start;
  logic [OW-1:0]        ahead_start;

  // Next values.
  logic [NUM_SLOTS-1:0] slot_valid_next;
  logic [NUM_SLOTS-1:0] slot_done_next;
  logic [OW-1:0]        write_offset_next;
  logic [IW-1:0]        alloc_index_next;
  logic [IW-1:0]        oldest_index_next;
  logic [OW-1:0]        oldest_start_next;
  logic [IW-1:0]        ahead_addr;

  // Result being formed for the accepted item.
  frba_pkg::status_t    res_status;
  logic [2:0]           res_slot;
  logic [7:0]           res_offset;

  // Request placement terms.
  logic                 accept;
  logic                 old_valid;
  logic                 wrapped;
  logic [SW-1:0]        end_contig;
  logic                 fit_contig;
  logic                 fit_zero;
  logic                 too_big;
  logic [OW-1:0]        req_start;
  logic                 start_we;
  logic [IW-1:0]        tgt_idx;
  logic                 tgt_in_range;
  logic                 oldest_ready;

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  assign old_valid  = slot_valid[oldest_index];
  assign wrapped    = old_valid && (oldest_start > write_offset);
  assign end_contig = SW'(write_offset) + SW'(alloc_size);
  assign too_big    = SW'(alloc_size) > SW'(BUF_BYTES);
  assign fit_contig = (end_contig <= SW'(BUF_BYTES)) &&
                      (!wrapped || (end_contig < SW'(oldest_start)));
  assign fit_zero   = !old_valid || (SW'(alloc_size) < SW'(oldest_start));
  assign req_start  = fit_contig ? write_offset : '0;

  assign tgt_in_range = int'(target_slot) < NUM_SLOTS;
  assign tgt_idx      = IW'(target_slot);
  assign oldest_ready = slot_valid[oldest_index] && slot_done[oldest_index];

  // Action decode: result fields and next descriptor state.
  always_comb begin
    slot_valid_next   = slot_valid;
    slot_done_next    = slot_done;
    write_offset_next = write_offset;
    alloc_index_next  = alloc_index;
    oldest_index_next = oldest_index;
    oldest_start_next = oldest_start;
    start_we          = 1'b0;
    res_status        = frba_pkg::ST_OK;
    res_slot          = 3'(alloc_index);
    res_offset        = '0;
    if (accept) begin
      unique case (frba_pkg::action_t'(action))
        frba_pkg::ACT_REQUEST: begin
          res_slot = 3'(alloc_index);
          if (slot_valid[alloc_index]) begin
            res_status = frba_pkg::ST_NO_SLOT;
          end else if (too_big || (!fit_contig && !fit_zero)) begin
            res_status = frba_pkg::ST_NO_SPACE;
          end else begin
            res_offset                    = 8'(req_start);
            slot_valid_next[alloc_index]  = 1'b1;
            slot_done_next[alloc_index]   = 1'b0;
            start_we                      = 1'b1;
            write_offset_next             = OW'(SW'(req_start) + SW'(alloc_size));
            alloc_index_next = (alloc_index == LAST_SLOT) ? '0 : alloc_index + IW'(1);
            // The oldest slot can only be written while it is empty.
            if (alloc_index == oldest_index) begin
              oldest_start_next = req_start;
            end
          end
        end
        frba_pkg::ACT_MARK: begin
          res_slot = target_slot;
          if (tgt_in_range && slot_valid[tgt_idx]) begin
            slot_done_next[tgt_idx] = 1'b1;
          end
        end
        frba_pkg::ACT_PEEK,
        frba_pkg::ACT_RELEASE: begin
          res_slot = 3'(oldest_index);
          if (!oldest_ready) begin
            res_status = frba_pkg::ST_NOT_READY;
          end else begin
            res_offset = 8'(oldest_start);
            if (frba_pkg::action_t'(action) == frba_pkg::ACT_RELEASE) begin
              slot_valid_next[oldest_index] = 1'b0;
              slot_done_next[oldest_index]  = 1'b0;
              oldest_index_next = (oldest_index == LAST_SLOT) ? '0 :
                                  oldest_index + IW'(1);
              oldest_start_next = ahead_start;
            end
          end
        end
        default: begin
          res_status = frba_pkg::ST_OK;
        end
      endcase
    end
  end

  // Prefetch address: the slot after the oldest one as it will be next cycle.
  assign ahead_addr = (oldest_index_next == LAST_SLOT) ? '0 : oldest_index_next + IW'(1);

  frba_start_mem #(
    .DEPTH (NUM_SLOTS),
    .WIDTH (OW)
  ) u_start_mem (
    .clk   (clk),
    .we    (start_we),
    .waddr (alloc_index),
    .wdata (req_start),
    .raddr (ahead_addr),
    .rdata (ahead_start)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid   <= '0;
      slot_done    <= '0;
      write_offset <= '0;
      alloc_index  <= '0;
      oldest_index <= '0;
    end else begin
      slot_valid   <= slot_valid_next;
      slot_done    <= slot_done_next;
      write_offset <= write_offset_next;
      alloc_index  <= alloc_index_next;
      oldest_index <= oldest_index_next;
    end
  end

  // Only meaningful while the oldest slot is valid, so it needs no reset.
  always_ff @(posedge clk) begin
    oldest_start <= oldest_start_next;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= res_status;
      slot_out   <= res_slot;
      offset_out <= res_offset;
    end
  end

`ifndef ASSERT_OFF
  // A finished mark never stands on a slot that is not in use.
  a_done_implies_valid: assert property (@(posedge clk) disable iff (rst)
    (slot_done & ~slot_valid) == '0)
    else $error("finished mark set on an unused slot");

  // The write offset never runs past the end of the buffer.
  a_offset_in_range: assert property (@(posedge clk) disable iff (rst)
    write_offset <= OW'(BUF_BYTES))
    else $error("write offset beyond buffer end");

  // Every accepted item leaves a result in the output register.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    accept |=> out_valid)
    else $error("accepted item produced no result");

  // A successful release frees the slot it reported.
  a_release_frees: assert property (@(posedge clk) disable iff (rst)
    (accept && (action == frba_pkg::ACT_RELEASE) && oldest_ready)
    |=> !slot_valid[$past(oldest_index)] && (status == frba_pkg::ST_OK))
    else $error("release did not free the oldest slot");
`endif

endmodule
